// File: hw/rtl/block_buffer_cache_lru_defines.svh
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_defines
// Assertion macros shared by the buffer cache RTL. They expect signals named
// clock and reset in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BBC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bbc: same-cycle check failed");

// next-cycle implication
`define BBC_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bbc: next-cycle check failed");

`else

`define BBC_ASSERT_IMP(lbl, ante, cons)
`define BBC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Types and constants of the buffer cache tag and replacement block.
// ----------------------------------------------------------------------------
package bbc_pkg;

   // field widths
   localparam int KIND_W     = 2;
   localparam int BLOCK_W    = 16;
   localparam int SEL_W      = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register map: one register, max_block, at byte address 0
   localparam logic CSR_IDX_MAX_BLOCK = 1'b0;
   localparam logic [BLOCK_W-1:0] MAX_BLOCK_RESET = 16'd2017;

   // access kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_READ    = 2'd0,
      KIND_WRITE   = 2'd1,
      KIND_PIN     = 2'd2,
      KIND_RELEASE = 2'd3
   } kind_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic decide;
      logic scan_step;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_scan;
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

// File: hw/rtl/bbc_req_if.sv
// ----------------------------------------------------------------------------
// bbc_req_if
// Access request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface bbc_req_if;
   logic                         valid;
   logic                         ready;
   logic [bbc_pkg::KIND_W-1:0]   kind;
   logic [bbc_pkg::BLOCK_W-1:0]  block_number;
   logic [bbc_pkg::SEL_W-1:0]    entry_select;

   modport source (output valid, kind, block_number, entry_select, input ready);
   modport sink   (input valid, kind, block_number, entry_select, output ready);
endinterface

// File: hw/rtl/bbc_rsp_if.sv
// ----------------------------------------------------------------------------
// bbc_rsp_if
// Access result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface bbc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bbc_pkg::SEL_W-1:0]  entry_index;
   logic                       hit;
   logic                       device_read;
   logic                       device_write;
   logic                       error;

   modport source (output valid, entry_index, hit, device_read, device_write, error,
                   input ready);
   modport sink   (input valid, entry_index, hit, device_read, device_write, error,
                   output ready);
endinterface

// File: hw/rtl/bbc_ctrl.sv
// ----------------------------------------------------------------------------
// bbc_ctrl
// Controller: sequences capture, lookup decision, victim scan and commit.
// ----------------------------------------------------------------------------
module bbc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bbc_pkg::status_type  st,
   output bbc_pkg::cmd_type     cmd
);

   bbc_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         bbc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = bbc_pkg::ST_DECIDE;
            end
         end
         bbc_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = st.need_scan ? bbc_pkg::ST_SCAN : bbc_pkg::ST_COMMIT;
         end
         bbc_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (st.scan_done) begin
               state_in = bbc_pkg::ST_COMMIT;
            end
         end
         bbc_pkg::ST_COMMIT: begin
            // hold until the result register can take the item
            if (st.out_free) begin
               cmd.commit = 1'b1;
               state_in   = bbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bbc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/bbc_datapath.sv
// ----------------------------------------------------------------------------
// bbc_datapath
// Datapath: tag lanes, age ranks, pin flags, victim scan, config register
// and the result register.
// ----------------------------------------------------------------------------
module bbc_datapath #(
   parameter int NUM_BUFFERS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // request fields
   input  logic [bbc_pkg::KIND_W-1:0]         req_kind,
   input  logic [bbc_pkg::BLOCK_W-1:0]        req_block_number,
   input  logic [bbc_pkg::SEL_W-1:0]          req_entry_select,
   // control
   input  bbc_pkg::cmd_type                   cmd,
   output bbc_pkg::status_type                st,
   // configuration
   input  logic                               csr_wr_en,
   input  logic [bbc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [bbc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [bbc_pkg::CSR_DATA_W-1:0]     csr_rdata,
   // result
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bbc_pkg::SEL_W-1:0]          rsp_entry_index,
   output logic                               rsp_hit,
   output logic                               rsp_device_read,
   output logic                               rsp_device_write,
   output logic                               rsp_error
);

   localparam int IDX_W = $clog2(NUM_BUFFERS);
   localparam logic [IDX_W-1:0] NEWEST = IDX_W'(NUM_BUFFERS - 1);

   // config
   logic [bbc_pkg::BLOCK_W-1:0] max_block_ff;

   // captured request
   bbc_pkg::kind_type            kind_ff;
   logic [bbc_pkg::BLOCK_W-1:0]  blk_ff;
   logic [bbc_pkg::SEL_W-1:0]    sel_ff;

   // decision
   logic [IDX_W-1:0] choice_ff;
   logic             hit_ff;
   logic             err_ff;
   logic             retag_ff;
   logic [IDX_W-1:0] scan_cnt_ff;

   // entry state
   logic [bbc_pkg::BLOCK_W-1:0] tag_ff  [NUM_BUFFERS];
   logic [IDX_W-1:0]            rank_ff [NUM_BUFFERS];
   logic [NUM_BUFFERS-1:0]      valid_ff;
   logic [NUM_BUFFERS-1:0]      pinned_ff;

   // result register
   logic                        rsp_valid_ff;
   logic [bbc_pkg::SEL_W-1:0]   rsp_entry_ff;
   logic                        rsp_hit_ff;
   logic                        rsp_dread_ff;
   logic                        rsp_dwrite_ff;
   logic                        rsp_err_ff;

   // lookup signals
   logic                   is_access;
   logic                   is_pin;
   logic                   is_release;
   logic                   in_range;
   logic [NUM_BUFFERS-1:0] match_vec;
   logic [NUM_BUFFERS-1:0] oldest_vec;
   logic [NUM_BUFFERS-1:0] scan_vec;
   logic [IDX_W-1:0]       match_idx;
   logic [IDX_W-1:0]       empty_idx;
   logic [IDX_W-1:0]       oldest_idx;
   logic [IDX_W-1:0]       scan_idx;
   logic                   match_any;
   logic                   empty_any;
   logic                   scan_hit;
   logic                   scan_last;
   logic                   dec_hit;
   logic [IDX_W-1:0]       dec_choice;
   logic                   sel_ok;
   logic [IDX_W-1:0]       sel_idx;
   logic                   touch;
   logic [IDX_W-1:0]       choice_rank;

   // lowest set bit of a lane vector
   function automatic logic [IDX_W-1:0] lowest_index(input logic [NUM_BUFFERS-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

   // request decode
   assign is_access  = (kind_ff == bbc_pkg::KIND_READ) || (kind_ff == bbc_pkg::KIND_WRITE);
   assign is_pin     = (kind_ff == bbc_pkg::KIND_PIN);
   assign is_release = (kind_ff == bbc_pkg::KIND_RELEASE);
   assign in_range   = (blk_ff <= max_block_ff);
   assign sel_ok     = (32'(sel_ff) < NUM_BUFFERS);
   assign sel_idx    = IDX_W'(sel_ff);

   // per-lane compares
   always_comb begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         match_vec[i]  = valid_ff[i] && (tag_ff[i] == blk_ff);
         oldest_vec[i] = (rank_ff[i] == '0);
         scan_vec[i]   = !pinned_ff[i] && (rank_ff[i] == scan_cnt_ff);
      end
   end

   assign match_idx  = lowest_index(match_vec);
   assign empty_idx  = lowest_index(~valid_ff);
   assign oldest_idx = lowest_index(oldest_vec);
   assign scan_idx   = lowest_index(scan_vec);
   assign match_any  = |match_vec;
   assign empty_any  = ~&valid_ff;
   assign scan_hit   = |scan_vec;
   assign scan_last  = (scan_cnt_ff == NEWEST);

   // hit, or else the matching or lowest empty entry
   assign dec_hit    = match_any && (kind_ff == bbc_pkg::KIND_READ);
   assign dec_choice = match_any ? match_idx : empty_idx;

   // status
   assign st.need_scan = is_access && in_range && !match_any && !empty_any;
   assign st.scan_done = scan_hit || scan_last;
   assign st.out_free  = !rsp_valid_ff || rsp_ready;

   // rank of the chosen entry
   always_comb begin
      choice_rank = '0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         if (choice_ff == IDX_W'(i)) begin
            choice_rank = choice_rank | rank_ff[i];
         end
      end
   end

   assign touch = hit_ff || retag_ff;

   // request capture, decision and victim scan
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= bbc_pkg::kind_type'(req_kind);
         blk_ff  <= req_block_number;
         sel_ff  <= req_entry_select;
      end
      if (cmd.decide) begin
         err_ff      <= is_access && !in_range;
         hit_ff      <= is_access && in_range && dec_hit;
         retag_ff    <= is_access && in_range && !dec_hit;
         choice_ff   <= dec_choice;
         scan_cnt_ff <= '0;
      end
      // oldest unpinned entry by rank order, else the oldest entry overall
      if (cmd.scan_step) begin
         choice_ff   <= scan_hit ? scan_idx : oldest_idx;
         scan_cnt_ff <= scan_cnt_ff + 1'b1;
      end
   end

   // config register, valid, pin and age state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_block_ff <= bbc_pkg::MAX_BLOCK_RESET;
         valid_ff     <= '0;
         pinned_ff    <= '0;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            rank_ff[i] <= IDX_W'(i);
         end
      end else begin
         if (csr_wr_en && (csr_addr[bbc_pkg::CSR_ADDR_W-1] == bbc_pkg::CSR_IDX_MAX_BLOCK)) begin
            max_block_ff <= csr_wdata[bbc_pkg::BLOCK_W-1:0];
         end
         if (cmd.commit) begin
            for (int i = 0; i < NUM_BUFFERS; i++) begin
               if (sel_ok && (sel_idx == IDX_W'(i))) begin
                  if (is_pin) begin
                     pinned_ff[i] <= 1'b1;
                  end
                  if (is_release) begin
                     pinned_ff[i] <= 1'b0;
                     valid_ff[i]  <= 1'b0;
                  end
               end
               if (retag_ff && (choice_ff == IDX_W'(i))) begin
                  valid_ff[i] <= 1'b1;
               end
               // chosen entry becomes newest, younger ones close the gap
               if (touch) begin
                  if (choice_ff == IDX_W'(i)) begin
                     rank_ff[i] <= NEWEST;
                  end else if (rank_ff[i] > choice_rank) begin
                     rank_ff[i] <= rank_ff[i] - 1'b1;
                  end
               end
            end
         end
      end
   end

   // tag write on retag
   always_ff @(posedge clock) begin
      if (cmd.commit && retag_ff) begin
         tag_ff[choice_ff] <= blk_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (!is_access) begin
            rsp_entry_ff <= sel_ff;
         end else if (err_ff) begin
            rsp_entry_ff <= '0;
         end else begin
            rsp_entry_ff <= bbc_pkg::SEL_W'(choice_ff);
         end
         rsp_hit_ff    <= hit_ff;
         rsp_dread_ff  <= retag_ff && (kind_ff == bbc_pkg::KIND_READ);
         rsp_dwrite_ff <= retag_ff && (kind_ff == bbc_pkg::KIND_WRITE);
         rsp_err_ff    <= err_ff;
      end
   end

   // config read-back
   assign csr_rdata = (csr_addr[bbc_pkg::CSR_ADDR_W-1] == bbc_pkg::CSR_IDX_MAX_BLOCK)
                    ? bbc_pkg::CSR_DATA_W'(max_block_ff) : '0;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_index  = rsp_entry_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_device_read  = rsp_dread_ff;
   assign rsp_device_write = rsp_dwrite_ff;
   assign rsp_error        = rsp_err_ff;

endmodule

// File: hw/rtl/block_buffer_cache_lru.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_lru
// Tag store and LRU replacement of a disk block buffer cache.
//
//   channel   direction  handshake          contents
//   req_bus   in         valid/ready        kind, block_number, entry_select
//   rsp_bus   out        valid/ready        entry_index, hit, device_read,
//                                           device_write, error
//   csr_*     in/out     APB, pready high   max_block at byte address 0
//
// One item at a time: accept, decide, commit when the block matches or an
// empty entry exists, and for pin, release and errors.
// Eviction adds a rank scan between decide and commit: one rank per cycle,
// oldest first, until an unpinned entry holds it or the newest rank is reached.
// A finished item waits in the result register; the commit stalls while it
// is still untaken. Synchronous active-high reset empties all entries.
// ----------------------------------------------------------------------------
`include "block_buffer_cache_lru_defines.svh"

module block_buffer_cache_lru #(
   parameter int NUM_BUFFERS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   bbc_req_if.sink                           req_bus,
   bbc_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bbc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bbc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bbc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   bbc_pkg::cmd_type    cmd;
   bbc_pkg::status_type st;
   logic                csr_wr_en;

   // apb write completes in the access phase
   assign csr_pready = 1'b1;
   assign csr_wr_en  = csr_psel && csr_penable && csr_pwrite;

   bbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .st        (st),
      .cmd       (cmd)
   );

   bbc_datapath #(
      .NUM_BUFFERS (NUM_BUFFERS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_bus.kind),
      .req_block_number (req_bus.block_number),
      .req_entry_select (req_bus.entry_select),
      .cmd              (cmd),
      .st               (st),
      .csr_wr_en        (csr_wr_en),
      .csr_addr         (csr_paddr),
      .csr_wdata        (csr_pwdata),
      .csr_rdata        (csr_prdata),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_entry_index  (rsp_bus.entry_index),
      .rsp_hit          (rsp_bus.hit),
      .rsp_device_read  (rsp_bus.device_read),
      .rsp_device_write (rsp_bus.device_write),
      .rsp_error        (rsp_bus.error)
   );

   // busy after taking an item
   `BBC_ASSERT_NXT(a_busy_after_accept, req_bus.valid && req_bus.ready, !req_bus.ready)
   // never commit over an untaken result
   `BBC_ASSERT_IMP(a_commit_room, cmd.commit, st.out_free)
   // at most one outcome flag per result
   `BBC_ASSERT_IMP(a_rsp_flags, rsp_bus.valid, $onehot0({rsp_bus.hit, rsp_bus.device_read, rsp_bus.device_write, rsp_bus.error}))

endmodule
